// ===== hw/rtl/led_strip_bit_encoder_macros.svh =====
// Assertion macros used by the back part of the LED strip bit encoder RTL.
`ifndef LED_STRIP_BIT_ENCODER_MACROS_SVH
`define LED_STRIP_BIT_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSBE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lsbe_pkg.sv =====
// Package with constants and types of the LED strip bit encoder.
package lsbe_pkg;

  localparam int BitsPerPixel = 24;
  localparam int HalfWords    = 24;
  localparam int SlotWidth    = 17;
  localparam int DutyWidth    = 16;
  localparam int PosWidth     = 6;
  localparam int BitCntWidth  = 5;

  localparam logic [BitCntWidth-1:0] LastBit = BitCntWidth'(BitsPerPixel - 1);

  localparam logic [15:0] LedCountReset = 16'd0;
  localparam logic [15:0] HighDutyReset = 16'd30;
  localparam logic [15:0] LowDutyReset  = 16'd12;

  localparam logic [1:0] CfgLedCount = 2'd0;
  localparam logic [1:0] CfgHighDuty = 2'd1;
  localparam logic [1:0] CfgLowDuty  = 2'd2;

  localparam logic ModeDisplay = 1'b0;
  localparam logic ModeRefill  = 1'b1;

  localparam logic KindDuty   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef struct packed {
    logic        is_status;
    logic        status_busy;
    logic        half;
    logic        is_pixel;
    logic        done;
    logic [23:0] pixel;
  } entry_t;

endpackage

// ===== hw/rtl/lsbe_queue.sv =====
// Two-entry queue between the front and back parts of the encoder.
module lsbe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lsbe_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lsbe_pkg::entry_t head
);

  lsbe_pkg::entry_t slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/lsbe_front.sv =====
// Front part: accepts words, tracks the frame and classifies each request.
module lsbe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      led_count,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_mode,
  input  logic             in_half_select,
  input  logic [7:0]       in_color_first,
  input  logic [7:0]       in_color_second,
  input  logic [7:0]       in_color_third,
  input  logic             q_full,
  output logic             q_push,
  output lsbe_pkg::entry_t q_entry
);

  logic [lsbe_pkg::SlotWidth-1:0] slot_r, slot_nxt;
  logic                           busy_r, busy_nxt;
  logic                           accept;
  logic [lsbe_pkg::SlotWidth-1:0] slot_inc;
  logic [lsbe_pkg::SlotWidth:0]   end_slot;
  logic                           is_pixel;
  logic                           done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign slot_inc = slot_r + 1'b1;
  assign end_slot = {2'b00, led_count} + 18'd2;
  assign is_pixel = (slot_r < {1'b0, led_count});
  assign done     = ({1'b0, slot_inc} >= end_slot);

  always_comb begin
    slot_nxt            = slot_r;
    busy_nxt            = busy_r;
    q_push              = 1'b0;
    q_entry.is_status   = (in_mode == lsbe_pkg::ModeDisplay);
    q_entry.status_busy = busy_r;
    q_entry.half        = in_half_select;
    q_entry.is_pixel    = is_pixel;
    q_entry.done        = done;
    q_entry.pixel       = {in_color_first, in_color_second, in_color_third};
    if (accept) begin
      if (in_mode == lsbe_pkg::ModeDisplay) begin
        q_push = 1'b1;
        if (!busy_r) begin
          slot_nxt = '0;
          busy_nxt = 1'b1;
        end
      end else if (busy_r) begin
        q_push   = 1'b1;
        slot_nxt = slot_inc;
        if (done) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      busy_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== hw/rtl/lsbe_back.sv =====
// Back part: expands queued requests into status and duty words.
`include "led_strip_bit_encoder_macros.svh"

module lsbe_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [15:0]                    high_duty,
  input  logic [15:0]                    low_duty,
  input  logic                           q_valid,
  input  lsbe_pkg::entry_t               q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic                           out_display_status,
  output logic [lsbe_pkg::DutyWidth-1:0] out_duty,
  output logic [lsbe_pkg::PosWidth-1:0]  out_buffer_position,
  output logic                           out_last_word,
  output logic                           out_frame_done
);

  logic [lsbe_pkg::BitCntWidth-1:0] bit_cnt_r, bit_cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             kind_r, status_r, last_r, done_r;
  logic [lsbe_pkg::DutyWidth-1:0]   duty_r, duty_nxt;
  logic [lsbe_pkg::PosWidth-1:0]    pos_r, pos_nxt;
  logic                             load;
  logic                             fire;
  logic                             last_bit;
  logic                             bit_val;

  assign load     = !out_valid_r || !out_stall;
  assign fire     = load && q_valid;
  assign last_bit = (bit_cnt_r == lsbe_pkg::LastBit);
  assign q_pop    = fire && (q_head.is_status || last_bit);
  assign bit_val  = q_head.pixel[lsbe_pkg::LastBit - bit_cnt_r];

  always_comb begin
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = load ? q_valid : out_valid_r;
    if (q_pop) begin
      bit_cnt_nxt = '0;
    end else if (fire) begin
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end
    duty_nxt = '0;
    if (q_head.is_pixel) begin
      duty_nxt = bit_val ? high_duty : low_duty;
    end
    pos_nxt = {1'b0, bit_cnt_r}
            + (q_head.half ? lsbe_pkg::PosWidth'(lsbe_pkg::HalfWords) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (q_head.is_status) begin
        kind_r   <= lsbe_pkg::KindStatus;
        status_r <= q_head.status_busy;
        duty_r   <= '0;
        pos_r    <= '0;
        last_r   <= 1'b0;
        done_r   <= 1'b0;
      end else begin
        kind_r   <= lsbe_pkg::KindDuty;
        status_r <= 1'b0;
        duty_r   <= duty_nxt;
        pos_r    <= pos_nxt;
        last_r   <= last_bit;
        done_r   <= q_head.done;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_display_status  = status_r;
  assign out_duty            = duty_r;
  assign out_buffer_position = pos_r;
  assign out_last_word       = last_r;
  assign out_frame_done      = done_r;

  `LSBE_ASSERT_SAME(a_bit_cnt_range, clk, rst_n, 1'b1, bit_cnt_r <= lsbe_pkg::LastBit, "bit count out of range")
  `LSBE_ASSERT_SAME(a_status_at_start, clk, rst_n, fire && q_head.is_status, bit_cnt_r == '0, "status word in the middle of a pixel")
  `LSBE_ASSERT_NEXT(a_pixel_pop_last, clk, rst_n, q_pop && !q_head.is_status, out_valid_r && out_last_word, "pixel entry left before its last word")

endmodule

// ===== hw/rtl/led_strip_bit_encoder.sv =====
// Top level of the LED strip bit encoder: configuration registers and part wiring.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+-----------------------------------------------
//  cfg     | in        | cfg_we           | cfg_index, cfg_data
//  in      | in        | in_valid/stall   | mode, half_select, color bytes
//  out     | out       | out_valid/stall  | kind, status, duty, position, last, frame done
//
// A display request yields one word, a refill in a frame 24 words, one per cycle unless out_stall.
// The back part's bit counter steps through a refill's words, one word per pixel bit.
// The two-entry queue lets a new word in while earlier ones are still being expanded.
// Reset is synchronous and active low; it clears the frame state and loads default duties.
// A stall on the output holds the current word and fills the queue before stalling input.
module led_strip_bit_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic        in_half_select,
  input  logic [7:0]  in_color_first,
  input  logic [7:0]  in_color_second,
  input  logic [7:0]  in_color_third,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_display_status,
  output logic [15:0] out_duty,
  output logic [5:0]  out_buffer_position,
  output logic        out_last_word,
  output logic        out_frame_done
);

  logic [15:0]      led_count_r;
  logic [15:0]      high_duty_r;
  logic [15:0]      low_duty_r;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  lsbe_pkg::entry_t q_in;
  lsbe_pkg::entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= lsbe_pkg::LedCountReset;
      high_duty_r <= lsbe_pkg::HighDutyReset;
      low_duty_r  <= lsbe_pkg::LowDutyReset;
    end else if (cfg_we) begin
      case (cfg_index)
        lsbe_pkg::CfgLedCount: led_count_r <= cfg_data;
        lsbe_pkg::CfgHighDuty: high_duty_r <= cfg_data;
        lsbe_pkg::CfgLowDuty:  low_duty_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  lsbe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .led_count       (led_count_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_half_select  (in_half_select),
    .in_color_first  (in_color_first),
    .in_color_second (in_color_second),
    .in_color_third  (in_color_third),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_in)
  );

  lsbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  lsbe_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .high_duty           (high_duty_r),
    .low_duty            (low_duty_r),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_display_status  (out_display_status),
    .out_duty            (out_duty),
    .out_buffer_position (out_buffer_position),
    .out_last_word       (out_last_word),
    .out_frame_done      (out_frame_done)
  );

endmodule
